>>> src/trimmed_mean_change_detector_unit_defines.svh
// assertion macros used by the trimmed mean change detector checker
`ifndef TRIMMED_MEAN_CHANGE_DETECTOR_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_CHANGE_DETECTOR_UNIT_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define TMCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define TMCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/tmcd_pkg.sv
// shared widths, constants and register indexes of the trimmed mean change detector
package tmcd_pkg;

    localparam int SAMPLE_W          = 10;
    localparam int THR_W             = 10;
    localparam int MEAN_INT_W        = 10;
    localparam int MEAN_FRAC_W       = 18;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 32;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 3;
    localparam int WINDOW_LEN_DEF    = 8;
    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
    localparam logic [THR_W-1:0]    THR_RESET  = THR_W'(4);

    // register index, taken from paddr[2]
    localparam logic REG_USE_FRACTION     = 1'b0;
    localparam logic REG_CHANGE_THRESHOLD = 1'b1;

endpackage

>>> src/trimmed_mean_change_detector_unit.sv
// trimmed moving average over a sample ring with a change flag against the last report
// one sample at a time: a new sample is taken only in idle, after the last result is registered
// the ring rotates once through its cells for min, max and sum, then a reciprocal multiply
// divides by WINDOW_LEN-2; a stalled result holds the next one in the last step
// sync active-low reset: ring entries to 1023, means and reports to 0, threshold to 4
module trimmed_mean_change_detector_unit #(
    parameter int WINDOW_LEN    = tmcd_pkg::WINDOW_LEN_DEF,
    parameter int FRACTION_BITS = tmcd_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tmcd_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmcd_pkg::M_TDATA_W-1:0]  m_tdata,   // [9:0] mean_int, [27:10] mean_frac,
                                                       // [28] changed
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmcd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tmcd_pkg::*;

    localparam int SUM_W     = $clog2(WINDOW_LEN * (2**SAMPLE_W - 1) + 1);
    localparam int Q_W       = SUM_W + FRACTION_BITS;
    localparam int SCAN_W    = $clog2(WINDOW_LEN);
    localparam int FRAC_STEP = (2**FRACTION_BITS) / 5 + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]             state_reg,     state_next;
    logic [SCAN_W-1:0]      scan_cnt_reg,  scan_cnt_next;
    logic [SAMPLE_W-1:0]    min_reg,       min_next;
    logic [SAMPLE_W-1:0]    max_reg,       max_next;
    logic [SUM_W-1:0]       sum_reg,       sum_next;
    logic                   use_frac_reg,  use_frac_next;
    logic [THR_W-1:0]       thr_reg,       thr_next;
    logic [MEAN_INT_W-1:0]  mean_int_reg,  mean_int_next;
    logic [Q_W-1:0]         mean_frac_reg, mean_frac_next;
    logic [MEAN_INT_W-1:0]  rep_int_reg,   rep_int_next;
    logic [Q_W-1:0]         rep_frac_reg,  rep_frac_next;
    logic                   m_tvalid_reg,  m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,   m_tdata_next;

    logic [SAMPLE_W-1:0]    tap [WINDOW_LEN];
    logic [SAMPLE_W-1:0]    head_in;
    logic                   advance;
    logic                   s_accept;
    logic                   cfg_write;
    logic                   out_free;
    logic                   div_start;
    logic                   div_done;
    logic [Q_W-1:0]         quotient;
    logic [SUM_W-1:0]       trimmed;
    logic [SAMPLE_W-1:0]    tail;
    logic [MEAN_INT_W-1:0]  new_int;
    logic [MEAN_INT_W-1:0]  diff_int;
    logic [Q_W-1:0]         diff_frac;
    logic                   changed;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign tail      = tap[WINDOW_LEN-1];

    // new sample enters at the head; while scanning the ring feeds its tail back round
    assign advance   = s_accept || (state_reg == ST_SCAN);
    assign head_in   = (state_reg == ST_IDLE) ? s_tdata[SAMPLE_W-1:0] : tail;

    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_ring
        tmcd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance_i (advance),
            .prev_i    ((i == 0) ? head_in : tap[(i == 0) ? 0 : i-1]),
            .value_o   (tap[i])
        );
    end

    assign trimmed   = sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg);
    assign div_start = (state_reg == ST_LOAD);

    tmcd_div #(
        .NUM_W     (SUM_W),
        .FRAC_BITS (FRACTION_BITS),
        .DIVISOR   (WINDOW_LEN - 2)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .num_i      (trimmed),
        .quotient_o (quotient),
        .done_o     (div_done)
    );

    // the integer mean is the fixed-point quotient with its fraction dropped
    assign new_int   = quotient[FRACTION_BITS +: MEAN_INT_W];
    assign diff_int  = (new_int >= rep_int_reg) ? new_int - rep_int_reg
                                                : rep_int_reg - new_int;
    assign diff_frac = (quotient >= rep_frac_reg) ? quotient - rep_frac_reg
                                                  : rep_frac_reg - quotient;
    assign changed   = use_frac_reg ? (diff_frac >= Q_W'(FRAC_STEP))
                                    : (diff_int >= thr_reg);

    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        use_frac_next  = use_frac_reg;
        thr_next       = thr_reg;
        mean_int_next  = mean_int_reg;
        mean_frac_next = mean_frac_reg;
        rep_int_next   = rep_int_reg;
        rep_frac_next  = rep_frac_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        if (cfg_write) begin
            case (paddr[2])
                REG_USE_FRACTION:     use_frac_next = pwdata[0];
                REG_CHANGE_THRESHOLD: thr_next      = pwdata[THR_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    min_next      = SAMPLE_MAX;
                    max_next      = '0;
                    sum_next      = '0;
                    scan_cnt_next = SCAN_W'(WINDOW_LEN - 1);
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tail < min_reg) begin
                    min_next = tail;
                end
                if (tail > max_reg) begin
                    max_next = tail;
                end
                sum_next = sum_reg + SUM_W'(tail);
                if (scan_cnt_reg == '0) begin
                    state_next = ST_LOAD;
                end else begin
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (use_frac_reg) begin
                        mean_frac_next = quotient;
                        if (changed) begin
                            rep_frac_next = quotient;
                        end
                    end else begin
                        mean_int_next = new_int;
                        if (changed) begin
                            rep_int_next = new_int;
                        end
                    end
                    m_tdata_next  = M_TDATA_W'({changed, MEAN_FRAC_W'(mean_frac_next),
                                                mean_int_next});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            use_frac_reg  <= 1'b0;
            thr_reg       <= THR_RESET;
            mean_int_reg  <= '0;
            mean_frac_reg <= '0;
            rep_int_reg   <= '0;
            rep_frac_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            use_frac_reg  <= use_frac_next;
            thr_reg       <= thr_next;
            mean_int_reg  <= mean_int_next;
            mean_frac_reg <= mean_frac_next;
            rep_int_reg   <= rep_int_next;
            rep_frac_reg  <= rep_frac_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg     <= min_next;
        max_reg     <= max_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        case (paddr[2])
            REG_USE_FRACTION:     prdata = APB_DATA_W'(use_frac_reg);
            REG_CHANGE_THRESHOLD: prdata = APB_DATA_W'(thr_reg);
            default:              prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/tmcd_cell.sv
// one window entry of the sample ring, passing its value on when the ring advances
module tmcd_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance_i,
    input  logic [tmcd_pkg::SAMPLE_W-1:0] prev_i,
    output logic [tmcd_pkg::SAMPLE_W-1:0] value_o
);
    import tmcd_pkg::*;

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;

    always_comb begin
        value_next = advance_i ? prev_i : value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= SAMPLE_MAX;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value_o = value_reg;

endmodule

>>> src/tmcd_div.sv
// division by a fixed divisor through a reciprocal multiply, numerator latched then one product
module tmcd_div #(
    parameter int NUM_W     = 13,
    parameter int FRAC_BITS = 8,
    parameter int DIVISOR   = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start_i,
    input  logic [NUM_W-1:0]           num_i,
    output logic [NUM_W+FRAC_BITS-1:0] quotient_o,
    output logic                       done_o
);
    localparam int Q_W   = NUM_W + FRAC_BITS;
    localparam int L_W   = $clog2(DIVISOR);
    localparam int M_W   = Q_W + 1;
    localparam int P_W   = NUM_W + M_W;
    localparam int SHIFT = Q_W + L_W - FRAC_BITS;
    // ceil(2^(Q_W+L_W) / DIVISOR) gives an exact floor quotient for every Q_W-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (Q_W + L_W)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

    logic [NUM_W-1:0] num_reg,   num_next;
    logic [P_W-1:0]   prod_reg,  prod_next;
    logic             stage_reg, stage_next;
    logic             done_reg,  done_next;

    always_comb begin
        num_next   = start_i ? num_i : num_reg;
        // numerator carries the fraction shift implicitly: num * 2^FRAC_BITS / DIVISOR
        prod_next  = stage_reg ? P_W'(num_reg) * P_W'(RECIP) : prod_reg;
        stage_next = start_i;
        done_next  = stage_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        prod_reg <= prod_next;
    end

    assign quotient_o = Q_W'(prod_reg >> SHIFT);
    assign done_o     = done_reg;

endmodule

>>> src/tmcd_checker.sv
// port-level checks of the trimmed mean change detector and their bind to the top level
`include "trimmed_mean_change_detector_unit_defines.svh"

module tmcd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tmcd_pkg::M_TDATA_W-1:0] m_tdata
);
    import tmcd_pkg::*;

    // no result survives a reset
    `TMCD_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    // a stalled result keeps its payload
    `TMCD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")

    // one request at a time: accepting a sample starts the window scan
    `TMCD_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready,
                 "sample taken while busy")

    // a fresh result only comes out of the finishing step, never from idle
    `TMCD_ASSERT(a_result_from_work, $rose(m_tvalid) |-> !$past(s_tready),
                 "result raised without work")

endmodule

bind trimmed_mean_change_detector_unit tmcd_checker u_tmcd_checker (.*);
